### src/bfs_pkg.sv
// shared types and constants for the byte ring fifo with peek and search
// no dependencies; imported by the interfaces, top level, controller, datapath and checker
`default_nettype none

package bfs_pkg;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned BSZ_W   = 9;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PUT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 3'd4;

  // register index
  localparam logic REG_BUFFER_SIZE = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  typedef struct packed {
    logic take;      // request accepted this cycle
    logic rd_fin;    // memory data for get or peek is ready
    logic scan;      // search scan in progress
    logic res_load;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic go_read;    // accepted request needs one memory read
    logic go_scan;    // accepted request starts a scan
    logic scan_hit;   // scanned entry matches
    logic scan_last;  // scanned entry is the last held one
  } status_t;

endpackage

`default_nettype wire

### src/bfs_in_if.sv
// request channel of the byte ring fifo: valid, ready and the request fields
// depends on bfs_pkg
`default_nettype none

interface bfs_in_if;
  import bfs_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [BYTE_W-1:0]   data_in;
  logic [BYTE_W-1:0]   position;

  modport source (output valid, kind, data_in, position, input ready);
  modport sink   (input valid, kind, data_in, position, output ready);
endinterface

`default_nettype wire

### src/bfs_out_if.sv
// result channel of the byte ring fifo: valid, ready and the result fields
// depends on bfs_pkg
`default_nettype none

interface bfs_out_if;
  import bfs_pkg::*;

  logic                valid;
  logic                ready;
  logic                ok;
  logic [BYTE_W-1:0]   data_out;
  logic [COUNT_W-1:0]  count;
  logic                empty_res;
  logic                full_res;

  modport source (output valid, ok, data_out, count, empty_res, full_res, input ready);
  modport sink   (input valid, ok, data_out, count, empty_res, full_res, output ready);
endinterface

`default_nettype wire

### src/byte_ring_fifo_with_peek_search.sv
// byte ring fifo with peek and search, top level
// timing: put, flush, failed or unknown requests give their result in the cycle after
// acceptance; get and peek pass the registered store read and the read state; search
// scans, one held entry compared per cycle through the single store read port
// throughput: 1 put or flush per cycle while results are taken; get and peek stall input
// reset: synchronous, empties the fifo and sets buffer_size to 256; no store clearing
`default_nettype none

module byte_ring_fifo_with_peek_search #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  bfs_in_if.sink                            in_ch,
  bfs_out_if.source                         out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bfs_pkg::APB_AW-1:0]   paddr,
  input  wire logic [bfs_pkg::APB_DW-1:0]   pwdata,
  output logic [bfs_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import bfs_pkg::*;

  cmd_t              cmd;
  status_t           st;
  logic              cfg_we;
  logic              reg_idx;
  logic [BSZ_W-1:0]  cfg_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1];
  assign cfg_we  = psel && penable && pwrite && (reg_idx == REG_BUFFER_SIZE);
  assign prdata  = (reg_idx == REG_BUFFER_SIZE) ? APB_DW'(cfg_rdata) : '0;

  bfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  bfs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .kind      (in_ch.kind),
    .data_in   (in_ch.data_in),
    .position  (in_ch.position),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[BSZ_W-1:0]),
    .cfg_rdata (cfg_rdata),
    .ok        (out_ch.ok),
    .data_out  (out_ch.data_out),
    .count     (out_ch.count),
    .empty_res (out_ch.empty_res),
    .full_res  (out_ch.full_res)
  );

endmodule

`default_nettype wire

### src/bfs_ctrl.sv
// controller of the byte ring fifo: state machine, request ready and result valid
// depends on bfs_pkg
`default_nettype none

module bfs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire bfs_pkg::status_t st,
  output bfs_pkg::cmd_t        cmd
);
  import bfs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.take     = 1'b0;
    cmd.rd_fin   = 1'b0;
    cmd.scan     = 1'b0;
    cmd.res_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd.take = 1'b1;
          if (st.go_read) begin
            state_nxt = S_READ;
          end else if (st.go_scan) begin
            state_nxt = S_SCAN;
          end else begin
            cmd.res_load = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.rd_fin   = 1'b1;
        cmd.res_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_hit || st.scan_last) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result slot frees on take and refills on load
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### src/bfs_datapath.sv
// datapath of the byte ring fifo: store memory, pointers, count, size register,
// scan registers and result register; depends on bfs_pkg
`default_nettype none

module bfs_datapath #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bfs_pkg::cmd_t                cmd,
  output bfs_pkg::status_t                  st,
  input  wire logic [bfs_pkg::KIND_W-1:0]   kind,
  input  wire logic [bfs_pkg::BYTE_W-1:0]   data_in,
  input  wire logic [bfs_pkg::BYTE_W-1:0]   position,
  input  wire logic                         cfg_we,
  input  wire logic [bfs_pkg::BSZ_W-1:0]    cfg_wdata,
  output logic [bfs_pkg::BSZ_W-1:0]         cfg_rdata,
  output logic                              ok,
  output logic [bfs_pkg::BYTE_W-1:0]        data_out,
  output logic [bfs_pkg::COUNT_W-1:0]       count,
  output logic                              empty_res,
  output logic                              full_res
);
  import bfs_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (CW > BYTE_W) ? CW : BYTE_W;
  localparam int unsigned SW = (CW > BSZ_W) ? CW : BSZ_W;
  localparam int unsigned RST_SIZE = (DEPTH < 256) ? DEPTH : 256;

  logic [BYTE_W-1:0]  store_r [DEPTH];
  logic [BYTE_W-1:0]  rdata_r;

  logic [PW-1:0]      head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      size_r, size_nxt;
  logic [BSZ_W-1:0]   bsz_r, bsz_nxt;
  logic [BYTE_W-1:0]  key_r, key_nxt;
  logic [PW-1:0]      scan_idx_r, scan_idx_nxt;
  logic [CW-1:0]      scan_left_r, scan_left_nxt;

  logic               ok_r, ok_nxt;
  logic [BYTE_W-1:0]  dout_r, dout_nxt;
  logic [COUNT_W-1:0] cnt_res_r, cnt_res_nxt;
  logic               empty_r, empty_nxt;
  logic               full_r, full_nxt;

  logic               mem_we, mem_re;
  logic [PW-1:0]      mem_addr;
  logic               put_ok, get_ok, peek_ok;
  logic [PW:0]        peek_sum;
  logic [PW-1:0]      peek_idx;
  logic [CW-1:0]      size_clamp;
  logic [CW-1:0]      cnt_src;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CW-1:0] s);
    logic [PW:0] n;
    n = (PW+1)'(p) + (PW+1)'(1);
    if (n >= (PW+1)'(s)) begin
      adv = '0;
    end else begin
      adv = n[PW-1:0];
    end
  endfunction

  assign put_ok  = (count_r != size_r);
  assign get_ok  = (count_r != '0);
  assign peek_ok = (KW'(position) < KW'(count_r));

  // offset wraps at the used size, not at the built depth
  assign peek_sum = (PW+1)'(head_r) + (PW+1)'(position);
  assign peek_idx = (peek_sum >= (PW+1)'(size_r)) ? PW'(peek_sum - (PW+1)'(size_r))
                                                  : peek_sum[PW-1:0];

  assign size_clamp = (cfg_wdata == '0)                  ? CW'(1) :
                      (SW'(cfg_wdata) > SW'(DEPTH))      ? CW'(DEPTH) :
                                                           CW'(cfg_wdata);

  assign st.go_read   = ((kind == KIND_GET) && get_ok) || ((kind == KIND_PEEK) && peek_ok);
  assign st.go_scan   = (kind == KIND_SEARCH) && get_ok;
  assign st.scan_hit  = (rdata_r == key_r);
  assign st.scan_last = (scan_left_r == CW'(1));

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    size_nxt      = size_r;
    bsz_nxt       = bsz_r;
    key_nxt       = key_r;
    scan_idx_nxt  = scan_idx_r;
    scan_left_nxt = scan_left_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = head_r;
    ok_nxt        = 1'b0;
    dout_nxt      = '0;
    cnt_src       = count_r;
    if (cfg_we) begin
      bsz_nxt   = cfg_wdata;
      size_nxt  = size_clamp;
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.take) begin
      case (kind)
        KIND_PUT: begin
          if (put_ok) begin
            mem_we    = 1'b1;
            mem_addr  = tail_r;
            tail_nxt  = adv(tail_r, size_r);
            count_nxt = count_r + CW'(1);
            ok_nxt    = 1'b1;
          end
        end
        KIND_GET: begin
          // pointer and count move now; data comes back next cycle
          if (get_ok) begin
            mem_re    = 1'b1;
            mem_addr  = head_r;
            head_nxt  = adv(head_r, size_r);
            count_nxt = count_r - CW'(1);
          end
        end
        KIND_PEEK: begin
          if (peek_ok) begin
            mem_re   = 1'b1;
            mem_addr = peek_idx;
          end
        end
        KIND_SEARCH: begin
          if (get_ok) begin
            mem_re        = 1'b1;
            mem_addr      = head_r;
            key_nxt       = data_in;
            scan_idx_nxt  = adv(head_r, size_r);
            scan_left_nxt = count_r;
          end
        end
        KIND_FLUSH: begin
          head_nxt  = tail_r;
          count_nxt = '0;
          ok_nxt    = 1'b1;
        end
        default: begin
        end
      endcase
      cnt_src = count_nxt;
    end else if (cmd.rd_fin) begin
      ok_nxt   = 1'b1;
      dout_nxt = rdata_r;
    end else if (cmd.scan) begin
      ok_nxt = st.scan_hit;
      if (!st.scan_hit && !st.scan_last) begin
        mem_re        = 1'b1;
        mem_addr      = scan_idx_r;
        scan_idx_nxt  = adv(scan_idx_r, size_r);
        scan_left_nxt = scan_left_r - CW'(1);
      end
    end
    cnt_res_nxt = COUNT_W'(cnt_src);
    empty_nxt   = (cnt_src == '0);
    full_nxt    = (cnt_src == size_r);
  end

  // single-port store with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_addr] <= data_in;
    end
    if (mem_re) begin
      rdata_r <= store_r[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      size_r  <= CW'(RST_SIZE);
      bsz_r   <= BSZ_W'(256);
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      size_r  <= size_nxt;
      bsz_r   <= bsz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    scan_idx_r  <= scan_idx_nxt;
    scan_left_r <= scan_left_nxt;
    if (cmd.res_load) begin
      ok_r      <= ok_nxt;
      dout_r    <= dout_nxt;
      cnt_res_r <= cnt_res_nxt;
      empty_r   <= empty_nxt;
      full_r    <= full_nxt;
    end
  end

  assign cfg_rdata = bsz_r;
  assign ok        = ok_r;
  assign data_out  = dout_r;
  assign count     = cnt_res_r;
  assign empty_res = empty_r;
  assign full_res  = full_r;

endmodule

`default_nettype wire

### src/bfs_checker.sv
// port-level checks for the byte ring fifo, bound to the top level
// depends on bfs_pkg and byte_ring_fifo_with_peek_search
`default_nettype none

module bfs_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic [bfs_pkg::KIND_W-1:0]   in_kind,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_ok,
  input wire logic [bfs_pkg::COUNT_W-1:0]  out_count,
  input wire logic                         out_empty_res,
  input wire logic                         out_full_res
);
  import bfs_pkg::*;

  // a waiting result is never overrun by a new request
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !(in_valid && in_ready))
    else $error("request accepted while result waits");

  // flush answers on the next cycle with an empty fifo
  a_flush_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == KIND_FLUSH)) |=> (out_valid && out_ok && out_empty_res))
    else $error("flush result wrong or late");

  // empty flag agrees with count and never coexists with full
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_empty_res == (out_count == '0)) && !(out_empty_res && out_full_res)))
    else $error("result flags inconsistent");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind byte_ring_fifo_with_peek_search bfs_checker u_bfs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_kind       (in_ch.kind),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_ok        (out_ch.ok),
  .out_count     (out_ch.count),
  .out_empty_res (out_ch.empty_res),
  .out_full_res  (out_ch.full_res)
);

`default_nettype wire
